// ----- rtl/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants of the line-fit block
// Sizes of the running sums, of the fit arithmetic and of the divider, and the
// records that pass between the accumulator, the job queue and the fit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  // Run length limit and the number of low sample bits that are used.
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;

  // Port widths.
  localparam int IN_W  = 16;
  localparam int OUT_W = 48;
  localparam int FRAC  = 16;
  localparam int HALF  = OUT_W / 2;

  // Running sums.
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;

  // Fit arithmetic.
  localparam int PROD_W = SQ_W + SX_W;
  localparam int NUM_W  = 2 * SX_W;
  localparam int INUM_W = OUT_W + SX_W + 1;
  localparam int DIV_W  = (NUM_W + FRAC > INUM_W) ? (NUM_W + FRAC) : INUM_W;
  localparam int DEN_W  = NUM_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Job queue between the accumulator and the fit engine.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SX_W-1:0]  sum_x;
    logic signed [SX_W-1:0]  sum_y;
    logic signed [SQ_W-1:0]  sum_xy;
    logic signed [SQ_W-1:0]  sum_xx;
    logic                    ovf;
  } fit_job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  // Clamp a wide signed value to the signed output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIV_W:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[DIV_W:OUT_W-1];
    hi_zeros = ~|v[DIV_W:OUT_W-1];
    if (hi_ones || hi_zeros) begin
      sat_out = v[OUT_W-1:0];
    end else if (v[DIV_W]) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/least_squares_line_fit.sv -----
// ----------------------------------------------------------------------------
// least_squares_line_fit: streaming straight-line least-squares fit
// Accumulates (x, y) pairs and, at the end of each run, reports slope and
// intercept in signed Q32.16 with degenerate and overflow flags.
// ----------------------------------------------------------------------------
// Usage. Sample pairs arrive on the in_ channel as valid/stall transactions,
// one per cycle at full rate; in_last_sample marks the final pair of a run.
// Each run produces exactly one transaction on the out_ channel, carrying
// slope = (n*Sxy - Sx*Sy)/(n*Sxx - Sx*Sx) and intercept = (Sy - slope*Sx)/n,
// both truncated toward zero and clamped to 48 signed bits. A zero
// denominator gives zeros with out_degenerate set. Pairs beyond MAX_SAMPLES
// in one run are dropped and out_overflowed is reported with that run.
// After the last pair of a run is taken, the fit engine runs its multiply
// and setup steps and two bit-serial divisions of 76 steps each, then hands
// the result to the output register and raises out_valid. A degenerate run
// skips both divisions.
// Throughput: one sample pair per cycle. Finished runs go to a two-entry job
// queue, and the input stalls while that queue is full, that is while two
// runs wait behind the one in the fit engine; short runs are therefore paced
// by the fit engine, which takes a new job only after the last one is handed
// out. in_stall does not depend on the samples or on out_stall directly.
// Reset (rst_n low, synchronous) clears the running sums, the queue, the fit
// sequencer and out_valid. While out_stall is high the result is held steady
// and the fit engine waits, after which the queue and then the input fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lsf_pkg::IN_W-1:0]   in_x_sample,
  input  logic signed [lsf_pkg::IN_W-1:0]   in_y_sample,
  input  logic                              in_last_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lsf_pkg::OUT_W-1:0]  out_slope,
  output logic signed [lsf_pkg::OUT_W-1:0]  out_intercept,
  output logic                              out_degenerate,
  output logic                              out_overflowed
);
  import lsf_pkg::*;

  // Front to queue.
  logic     q_push;
  logic     q_full;
  fit_job_t push_job;

  // Queue to fit engine.
  logic     q_pop;
  logic     q_empty;
  fit_job_t pop_job;

  // Fit engine to divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // The front end sums each accepted pair in the cycle it is taken and, on
  // the last pair of a run, pushes the completed sums as one job.
  lsf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_sample    (in_x_sample),
    .in_y_sample    (in_y_sample),
    .in_last_sample (in_last_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // The queue decouples sample intake from the long fit computation.
  lsf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  // The divider is shared between the slope and the intercept division.
  lsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The fit engine sequences the multiplies and divisions of one job and
  // owns the output register.
  lsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_degenerate (out_degenerate),
    .out_overflowed (out_overflowed)
  );

endmodule

`default_nettype wire

// ----- rtl/lsf_front.sv -----
// ----------------------------------------------------------------------------
// lsf_front: sample accumulator
// Takes one sample pair per cycle unless the job queue is full, keeps the
// count and the four sums, and on the last pair of a run queues the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lsf_pkg::IN_W-1:0]   in_x_sample,
  input  logic signed [lsf_pkg::IN_W-1:0]   in_y_sample,
  input  logic                              in_last_sample,
  input  logic                              q_full,
  output logic                              q_push,
  output lsf_pkg::fit_job_t                 q_job
);
  import lsf_pkg::*;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_acc;
  logic signed [SX_W-1:0] sx_r, sx_nxt, sx_acc;
  logic signed [SX_W-1:0] sy_r, sy_nxt, sy_acc;
  logic signed [SQ_W-1:0] sxy_r, sxy_nxt, sxy_acc;
  logic signed [SQ_W-1:0] sxx_r, sxx_nxt, sxx_acc;
  logic                   ovf_r, ovf_nxt, ovf_acc;

  logic signed [SAMPLE_BITS-1:0]   x_s, y_s;
  logic signed [2*SAMPLE_BITS-1:0] xy_p, xx_p;
  logic                            accept;
  logic                            at_limit;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign at_limit = (cnt_r == CNT_W'(MAX_SAMPLES));
  assign q_push   = accept && in_last_sample;

  always_comb begin
    x_s  = SAMPLE_BITS'(in_x_sample);
    y_s  = SAMPLE_BITS'(in_y_sample);
    xy_p = x_s * y_s;
    xx_p = x_s * x_s;

    cnt_acc = cnt_r;
    sx_acc  = sx_r;
    sy_acc  = sy_r;
    sxy_acc = sxy_r;
    sxx_acc = sxx_r;
    ovf_acc = ovf_r;
    if (accept) begin
      if (at_limit) begin
        ovf_acc = 1'b1;
      end else begin
        cnt_acc = cnt_r + CNT_W'(1);
        sx_acc  = sx_r + SX_W'(x_s);
        sy_acc  = sy_r + SX_W'(y_s);
        sxy_acc = sxy_r + SQ_W'(xy_p);
        sxx_acc = sxx_r + SQ_W'(xx_p);
      end
    end

    q_job.count  = cnt_acc;
    q_job.sum_x  = sx_acc;
    q_job.sum_y  = sy_acc;
    q_job.sum_xy = sxy_acc;
    q_job.sum_xx = sxx_acc;
    q_job.ovf    = ovf_acc;

    // The run ends here: the sums go to the queue and start again from zero.
    if (q_push) begin
      cnt_nxt = '0;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sxy_nxt = '0;
      sxx_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      cnt_nxt = cnt_acc;
      sx_nxt  = sx_acc;
      sy_nxt  = sy_acc;
      sxy_nxt = sxy_acc;
      sxx_nxt = sxx_acc;
      ovf_nxt = ovf_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxy_r <= sxy_nxt;
      sxx_r <= sxx_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lsf_fifo.sv -----
// ----------------------------------------------------------------------------
// lsf_fifo: job queue
// A short queue of finished run sums between the accumulator and the fit
// engine, so that each side can wait without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lsf_pkg::fit_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output lsf_pkg::fit_job_t pop_job
);
  import lsf_pkg::*;

  fit_job_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("job queue holds more entries than its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/lsf_div.sv -----
// ----------------------------------------------------------------------------
// lsf_div: unsigned radix-2 divider
// Restoring long division, one quotient bit per cycle over DIV_W steps;
// pulses done for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lsf_pkg::div_req_t req,
  output lsf_pkg::div_rsp_t rsp
);
  import lsf_pkg::*;

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = DCNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while a division is in progress");

endmodule

`default_nettype wire

// ----- rtl/lsf_back.sv -----
// ----------------------------------------------------------------------------
// lsf_back: fit engine
// Takes the sums of one run from the queue, forms numerator and denominator
// with one shared multiplier, runs the two divisions on the divider (none
// for a degenerate run) and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  lsf_pkg::fit_job_t                 q_job,
  output logic                              q_pop,
  output lsf_pkg::div_req_t                 div_req,
  input  lsf_pkg::div_rsp_t                 div_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lsf_pkg::OUT_W-1:0]  out_slope,
  output logic signed [lsf_pkg::OUT_W-1:0]  out_intercept,
  output logic                              out_degenerate,
  output logic                              out_overflowed
);
  import lsf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_MUL3   = 4'd3;
  localparam logic [3:0] S_MUL4   = 4'd4;
  localparam logic [3:0] S_DEN    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_DIV1   = 4'd7;
  localparam logic [3:0] S_IMUL1  = 4'd8;
  localparam logic [3:0] S_IMUL2  = 4'd9;
  localparam logic [3:0] S_INUM   = 4'd10;
  localparam logic [3:0] S_ISTART = 4'd11;
  localparam logic [3:0] S_DIV2   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]               state_r, state_nxt;

  logic [CNT_W-1:0]         jn_r, jn_nxt;
  logic signed [SX_W-1:0]   sx_r, sx_nxt;
  logic signed [SX_W-1:0]   sy_r, sy_nxt;
  logic signed [SQ_W-1:0]   sxy_r, sxy_nxt;
  logic signed [SQ_W-1:0]   sxx_r, sxx_nxt;
  logic                     ovf_r, ovf_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic signed [NUM_W-1:0]  den_r, den_nxt;
  logic signed [INUM_W-1:0] inum_r, inum_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [OUT_W-1:0]  slope_r, slope_nxt;
  logic signed [OUT_W-1:0]  icpt_r, icpt_nxt;
  logic                     degen_r, degen_nxt;

  logic                     ov_r, ov_nxt;
  logic signed [OUT_W-1:0]  oslope_r, oslope_nxt;
  logic signed [OUT_W-1:0]  oicpt_r, oicpt_nxt;
  logic                     odegen_r, odegen_nxt;
  logic                     oovf_r, oovf_nxt;

  logic signed [SQ_W-1:0]   mul_a;
  logic signed [SX_W-1:0]   mul_b;
  logic [NUM_W+FRAC-1:0]    nsh, nsh_mag;
  logic [NUM_W-1:0]         den_u, den_mag;
  logic [INUM_W-1:0]        inum_u, inum_mag;
  logic [DIV_W:0]           q_ext, q_sgn;
  logic signed [OUT_W-1:0]  q_sat;
  logic                     out_free;

  assign out_valid      = ov_r;
  assign out_slope      = oslope_r;
  assign out_intercept  = oicpt_r;
  assign out_degenerate = odegen_r;
  assign out_overflowed = oovf_r;
  assign out_free       = !ov_r || !out_stall;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        mul_a = sxy_r;
        mul_b = SX_W'({1'b0, jn_r});
      end
      S_MUL2: begin
        mul_a = SQ_W'(sx_r);
        mul_b = sy_r;
      end
      S_MUL3: begin
        mul_a = sxx_r;
        mul_b = SX_W'({1'b0, jn_r});
      end
      S_MUL4: begin
        mul_a = SQ_W'(sx_r);
        mul_b = sx_r;
      end
      S_IMUL1: begin
        mul_a = SQ_W'({1'b0, slope_r[HALF-1:0]});
        mul_b = sx_r;
      end
      S_IMUL2: begin
        mul_a = SQ_W'($signed(slope_r[OUT_W-1:HALF]));
        mul_b = sx_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    nsh      = {num_r, {FRAC{1'b0}}};
    nsh_mag  = num_r[NUM_W-1] ? -nsh : nsh;
    den_u    = den_r;
    den_mag  = den_u[NUM_W-1] ? -den_u : den_u;
    inum_u   = inum_r;
    inum_mag = inum_u[INUM_W-1] ? -inum_u : inum_u;
    q_ext    = {1'b0, div_rsp.quot};
    q_sgn    = neg_r ? -q_ext : q_ext;
    q_sat    = sat_out($signed(q_sgn));
  end

  always_comb begin
    state_nxt  = state_r;
    jn_nxt     = jn_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    sxy_nxt    = sxy_r;
    sxx_nxt    = sxx_r;
    ovf_nxt    = ovf_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    inum_nxt   = inum_r;
    neg_nxt    = neg_r;
    slope_nxt  = slope_r;
    icpt_nxt   = icpt_r;
    degen_nxt  = degen_r;
    ov_nxt     = ov_r && out_stall;
    oslope_nxt = oslope_r;
    oicpt_nxt  = oicpt_r;
    odegen_nxt = odegen_r;
    oovf_nxt   = oovf_r;
    q_pop      = 1'b0;
    div_req    = '0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          jn_nxt    = q_job.count;
          sx_nxt    = q_job.sum_x;
          sy_nxt    = q_job.sum_y;
          sxy_nxt   = q_job.sum_xy;
          sxx_nxt   = q_job.sum_xx;
          ovf_nxt   = q_job.ovf;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        num_nxt   = NUM_W'(prod_r);
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        num_nxt   = num_r - NUM_W'(prod_r);
        state_nxt = S_MUL4;
      end
      S_MUL4: begin
        den_nxt   = NUM_W'(prod_r);
        state_nxt = S_DEN;
      end
      S_DEN: begin
        den_nxt   = den_r - NUM_W'(prod_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (den_r == '0) begin
          // Degenerate run (all x equal, or a single point): zero result.
          slope_nxt = '0;
          icpt_nxt  = '0;
          degen_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(nsh_mag);
          div_req.den   = DEN_W'(den_mag);
          neg_nxt       = num_r[NUM_W-1] ^ den_r[NUM_W-1];
          degen_nxt     = 1'b0;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          slope_nxt = q_sat;
          state_nxt = S_IMUL1;
        end
      end
      S_IMUL1: begin
        state_nxt = S_IMUL2;
      end
      S_IMUL2: begin
        // Low half of slope * Sx comes back first.
        inum_nxt  = (INUM_W'(sy_r) <<< FRAC) - INUM_W'(prod_r);
        state_nxt = S_INUM;
      end
      S_INUM: begin
        inum_nxt  = inum_r - (INUM_W'(prod_r) <<< HALF);
        state_nxt = S_ISTART;
      end
      S_ISTART: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(inum_mag);
        div_req.den   = DEN_W'(jn_r);
        neg_nxt       = inum_r[INUM_W-1];
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          icpt_nxt  = q_sat;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          oslope_nxt = slope_r;
          oicpt_nxt  = icpt_r;
          odegen_nxt = degen_r;
          oovf_nxt   = ovf_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    jn_r     <= jn_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    sxy_r    <= sxy_nxt;
    sxx_r    <= sxx_nxt;
    ovf_r    <= ovf_nxt;
    prod_r   <= prod_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    inum_r   <= inum_nxt;
    neg_r    <= neg_nxt;
    slope_r  <= slope_nxt;
    icpt_r   <= icpt_nxt;
    degen_r  <= degen_nxt;
    oslope_r <= oslope_nxt;
    oicpt_r  <= oicpt_nxt;
    odegen_r <= odegen_nxt;
    oovf_r   <= oovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished while the engine was not waiting on it");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MUL1))
    else $error("job popped without starting the fit sequence");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for least_squares_line_fit
// Streams runs of (x, y) sample pairs through the fit block with random sender
// gaps and receiver stalls, and compares every fit against a typed-in fit or a
// behavioral line-fit calculator kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsf_pkg::IN_W;
  import lsf_pkg::OUT_W;
  import lsf_pkg::FRAC;
  import lsf_pkg::MAX_SAMPLES;
  import lsf_pkg::SAMPLE_BITS;

  // Number of sample pairs in the random part, and the receiver's long hold.
  localparam int RANDOM_PAIRS = 1530;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AFTER   = 20;
  // Index of the random run that is made longer than the sample limit.
  localparam int LONG_RUN_IDX = 20;
  // Watch time for extra fits once every owed fit has come out.
  localparam int DRAIN_CYCLES = 400;

  // The fit arithmetic is exact on 128-bit signed words.
  typedef logic signed [127:0] wide_t;
  localparam wide_t SAT_HI = 128'sh7FFF_FFFF_FFFF;
  localparam wide_t SAT_LO = -128'sh8000_0000_0000;

  typedef struct packed {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic                    degenerate;
    logic                    overflowed;
  } line_fit_t;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic                   last;
    logic                   typed;
    line_fit_t              fit;
  } pair_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [IN_W-1:0]  in_x_sample;
  logic signed [IN_W-1:0]  in_y_sample;
  logic                    in_last_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_slope;
  logic signed [OUT_W-1:0] out_intercept;
  logic                    out_degenerate;
  logic                    out_overflowed;

  least_squares_line_fit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_sample    (in_x_sample),
    .in_y_sample    (in_y_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_degenerate (out_degenerate),
    .out_overflowed (out_overflowed)
  );

  // Fits still owed by the block, oldest first.
  line_fit_t fit_expect_q[$];
  pair_row_t directed_rows[$];
  int        fits_seen;
  bit        failed;
  int        burst_left;

  // Running sums of the bench's own line-fit calculator.
  longint      acc_x;
  longint      acc_y;
  longint      acc_xy;
  longint      acc_xx;
  int unsigned acc_n;
  bit          acc_ovf;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is bounded; a hang or a lost fit ends here.
  initial begin
    #20ms;
    $display("least_squares_line_fit test failed");
    $finish;
  end

  // Only the low SAMPLE_BITS of a sample take part, read as signed.
  function automatic longint sample_value(input logic [IN_W-1:0] raw);
    logic signed [SAMPLE_BITS-1:0] low;
    low = raw[SAMPLE_BITS-1:0];
    return low;
  endfunction

  // Clamp to the signed Q32.16 output range.
  function automatic logic signed [OUT_W-1:0] clamp_q32_16(input wide_t v);
    if (v > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  // Folds one accepted pair into the sums. On the pair that closes a run it
  // returns the fit the block must report, and the sums start over.
  task automatic fit_accumulate(input logic [IN_W-1:0] xr, input logic [IN_W-1:0] yr,
                                input logic last, output bit fit_due,
                                output line_fit_t fit);
    longint                  x;
    longint                  y;
    wide_t                   wn;
    wide_t                   wx;
    wide_t                   wy;
    wide_t                   wxy;
    wide_t                   wxx;
    wide_t                   num;
    wide_t                   den;
    wide_t                   ws;
    logic signed [OUT_W-1:0] slope_q;
    x = sample_value(xr);
    y = sample_value(yr);
    fit_due = 1'b0;
    fit = '0;
    // A pair beyond the limit is dropped but marks the run as too long.
    if (acc_n >= MAX_SAMPLES) begin
      acc_ovf = 1'b1;
    end else begin
      acc_x  += x;
      acc_y  += y;
      acc_xy += x * y;
      acc_xx += x * x;
      acc_n++;
    end
    if (last) begin
      fit_due = 1'b1;
      fit.degenerate = 1'b1;
      fit.overflowed = acc_ovf;
      if (acc_n != 0) begin
        wn  = acc_n;
        wx  = acc_x;
        wy  = acc_y;
        wxy = acc_xy;
        wxx = acc_xx;
        num = wn * wxy - wx * wy;
        den = wn * wxx - wx * wx;
        // A zero denominator (all x equal, or a single point) leaves zeros.
        if (den != 0) begin
          fit.degenerate = 1'b0;
          slope_q = clamp_q32_16((num <<< FRAC) / den);
          // The intercept is built on the already clamped slope.
          ws = slope_q;
          fit.slope = slope_q;
          fit.intercept = clamp_q32_16(((wy <<< FRAC) - ws * wx) / wn);
        end
      end
      acc_x   = 0;
      acc_y   = 0;
      acc_xy  = 0;
      acc_xx  = 0;
      acc_n   = 0;
      acc_ovf = 1'b0;
    end
  endtask

  // Offers one pair. The sender works in bursts; when a burst is used up a
  // random gap (sometimes none) comes before the next one. Once the pair is
  // taken, the owed fit is queued: the typed-in one where the row gives it.
  task automatic send_pair(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                           input logic last, input bit typed,
                           input line_fit_t typed_fit);
    int        gap;
    bit        fit_due;
    line_fit_t fit;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_x_sample    <= x;
    in_y_sample    <= y;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    fit_accumulate(x, y, last, fit_due, fit);
    if (fit_due) begin
      fit_expect_q.push_back(typed ? typed_fit : fit);
    end
  endtask

  // Stops offering pairs until every owed fit has come out.
  task automatic wait_fits_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (fit_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                         input logic last, input bit typed,
                         input logic signed [OUT_W-1:0] slope,
                         input logic signed [OUT_W-1:0] intercept,
                         input logic degenerate);
    pair_row_t row;
    row.x                  = x;
    row.y                  = y;
    row.last               = last;
    row.typed              = typed;
    row.fit.slope          = slope;
    row.fit.intercept      = intercept;
    row.fit.degenerate     = degenerate;
    row.fit.overflowed     = 1'b0;
    directed_rows.push_back(row);
  endtask

  // Picks a sample value in one of several styles: full range, the range
  // corners and sign boundary, or small values near zero.
  function automatic logic [IN_W-1:0] pick_sample(input int style);
    if (style == 1) begin
      case ($urandom_range(0, 5))
        0:       return 16'sh8000;
        1:       return 16'sh8001;
        2:       return 16'shFFFF;
        3:       return 16'sh0000;
        4:       return 16'sh7FFE;
        default: return 16'sh7FFF;
      endcase
    end else if (style == 2) begin
      return IN_W'($urandom_range(0, 16) - 8);
    end
    return IN_W'($urandom);
  endfunction

  // Receiver: changes its stall pattern every so often, and once, after a
  // number of fits, holds off for a long stretch so that the job queue fills
  // and the block pushes back on the sender.
  initial begin
    int mode;
    int span;
    bit held;
    mode = 0;
    span = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && fits_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= (span % 3 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result monitor: each fit taken from the block is checked field by field
  // against the oldest owed fit.
  always @(posedge clk) begin
    line_fit_t want;
    if (rst_n && out_valid && !out_stall) begin
      fits_seen++;
      if (fit_expect_q.size() == 0) begin
        $display("%0t: fit with none owed: slope %0d intercept %0d degenerate %0b overflowed %0b",
                 $time, out_slope, out_intercept, out_degenerate, out_overflowed);
        failed = 1'b1;
      end else begin
        want = fit_expect_q.pop_front();
        if (out_slope !== want.slope) begin
          $display("%0t: slope expected %0d actual %0d", $time, want.slope, out_slope);
          failed = 1'b1;
        end
        if (out_intercept !== want.intercept) begin
          $display("%0t: intercept expected %0d actual %0d",
                   $time, want.intercept, out_intercept);
          failed = 1'b1;
        end
        if (out_degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b",
                   $time, want.degenerate, out_degenerate);
          failed = 1'b1;
        end
        if (out_overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b",
                   $time, want.overflowed, out_overflowed);
          failed = 1'b1;
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then random runs.
  initial begin
    int        sent;
    int        run_idx;
    int        run_len;
    int        mode;
    int        pick;
    logic [IN_W-1:0] run_x;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    line_fit_t none;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_x_sample    = '0;
    in_y_sample    = '0;
    in_last_sample = 1'b0;
    out_stall      = 1'b0;
    fits_seen      = 0;
    failed         = 1'b0;
    burst_left     = 0;
    acc_x          = 0;
    acc_y          = 0;
    acc_xy         = 0;
    acc_xx         = 0;
    acc_n          = 0;
    acc_ovf        = 1'b0;
    none           = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Fits that follow at a glance are typed in: a single
    // point and equal x values are degenerate, points on y = x give slope
    // 1.0, the corners on y = -x - 1 give slope and intercept of -1.0, and a
    // flat line gives zeros. The rest go to the calculator.
    add_row(16'sd5,      16'sd7,      1'b1, 1'b1, 0, 0, 1'b1);
    add_row(16'sd3,      -16'sd4,     1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd3,      16'sd9,      1'b1, 1'b1, 0, 0, 1'b1);
    add_row(16'sd0,      16'sd0,      1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd1,      16'sd1,      1'b1, 1'b1, 65536, 0, 1'b0);
    add_row(16'sh8000,   16'sh8000,   1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sh7FFF,   16'sh7FFF,   1'b1, 1'b1, 65536, 0, 1'b0);
    add_row(16'sh8000,   16'sh7FFF,   1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sh7FFF,   16'sh8000,   1'b1, 1'b1, -65536, -65536, 1'b0);
    add_row(16'sh8000,   16'sd0,      1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sh7FFF,   16'sd0,      1'b1, 1'b1, 0, 0, 1'b0);
    add_row(-16'sd1,     -16'sd1,     1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd1,      16'sd1,      1'b1, 1'b1, 65536, 0, 1'b0);
    // Steepest lines the samples allow, with intercepts near the range edge.
    add_row(16'sh7FFE,   16'sh8000,   1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sh7FFF,   16'sh7FFF,   1'b1, 1'b0, 0, 0, 1'b0);
    add_row(16'sh8000,   16'sh7FFF,   1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sh8001,   16'sh8000,   1'b1, 1'b0, 0, 0, 1'b0);
    // Three-point runs whose quotients truncate toward zero.
    add_row(16'sd0,      16'sd0,      1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd2,      16'sd1,      1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd4,      16'sd5,      1'b1, 1'b0, 0, 0, 1'b0);
    add_row(16'sd0,      16'sd0,      1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd1,      -16'sd1,     1'b0, 1'b0, 0, 0, 1'b0);
    add_row(16'sd3,      16'sd2,      1'b1, 1'b0, 0, 0, 1'b0);
    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].fit);
    end
    wait_fits_drained();

    // Random runs. Most are short, some long, some degenerate (one point or
    // a fixed x). One run goes past the sample limit, so that the pair at
    // the limit is still summed, the next is dropped, and the last pair,
    // also beyond it, still triggers the fit with the overflow flag.
    sent = 0;
    run_idx = 0;
    while (sent < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 19);
      if (run_idx == LONG_RUN_IDX) begin
        wait_fits_drained();
        run_len = MAX_SAMPLES + 2;
      end else if (pick < 3) begin
        run_len = 1;
      end else if (pick < 16) begin
        run_len = $urandom_range(2, 12);
      end else begin
        run_len = $urandom_range(13, 60);
      end
      mode  = (run_idx == LONG_RUN_IDX) ? 0 : $urandom_range(0, 9);
      run_x = pick_sample($urandom_range(0, 2));
      for (int k = 0; k < run_len; k++) begin
        case (mode)
          5, 6: begin
            x = pick_sample(1);
            y = pick_sample($urandom_range(0, 1));
          end
          7: begin
            x = pick_sample(2);
            y = pick_sample(2);
          end
          8: begin
            x = run_x;
            y = pick_sample(0);
          end
          9: begin
            // Nearly straight line with a little noise.
            x = IN_W'(k * 37 - 300);
            y = IN_W'(3 * (k * 37 - 300) + $urandom_range(0, 6) - 3);
          end
          default: begin
            x = pick_sample(0);
            y = pick_sample(0);
          end
        endcase
        send_pair(x, y, k == run_len - 1, 1'b0, none);
        sent++;
      end
      run_idx++;
    end

    // Let every owed fit arrive, then watch a while for anything extra.
    @(negedge clk);
    in_valid <= 1'b0;
    while (fit_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("least_squares_line_fit test passed");
    end else begin
      $display("least_squares_line_fit test failed");
    end
    $finish;
  end

endmodule
